// ----- rtl/mcet_pkg.sv -----
// Shared types, codes and constants of the mission clock and event timers.
package mcet_pkg;

	// Sizes of state and fields.
	localparam int NUM_EVENT_TIMERS = 2;
	localparam int NUM_MODE_REGS    = 2;
	localparam int CLK_W            = 36;
	localparam int EV_W             = 23;
	localparam int DELTA_W          = 16;
	localparam int TSEL_W           = 1;
	localparam int MODE_W           = 2;
	localparam int CFG_IDX_W        = 2;
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
	localparam int NUM_STAGES       = 7;

	// Time constants: limits in milliseconds, the day wrap and the test display value.
	localparam logic [CLK_W-1:0] DAYS400_MS   = 36'd34560000000;
	localparam logic [EV_W-1:0]  EVENT_MAX_MS = 23'd5999999;
	localparam logic [8:0]       DAYS_WRAP    = 9'd400;
	localparam logic [6:0]       TEST_SHOW    = 7'd88;

	// Item kinds.
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_LOAD  = 3'd1;
	localparam logic [2:0] KIND_START = 3'd2;
	localparam logic [2:0] KIND_STOP  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// Event timer modes.
	localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEST = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIMER0_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER1_MODE = 2'd1;

	// Reciprocals for exact division by constants: q = (x * M) >> S.
	// Milliseconds split, upper 18 bits of the accumulator by 1000.
	localparam logic [36:0] M_KILO_HI = 37'd268436;        // S = 28
	// Milliseconds split, 28-bit remainder word by 1000.
	localparam logic [56:0] M_KILO_LO = 57'd274877907;     // S = 38
	// Seconds by 60, 26-bit operand.
	localparam logic [52:0] M_SIXTY_S = 53'd71582789;      // S = 32
	// Minutes by 60, 20-bit operand.
	localparam logic [40:0] M_SIXTY_M = 41'd1118482;       // S = 26
	// Hours by 24, 14-bit operand.
	localparam logic [28:0] M_DAY_H   = 29'd21846;         // S = 19
	// Event timer milliseconds by 1000, 23-bit operand.
	localparam logic [46:0] M_EV_KILO = 47'd8589935;       // S = 33
	// Event timer seconds by 60, 13-bit operand.
	localparam logic [26:0] M_EV_SIXTY = 27'd8739;         // S = 19

	// One input item.
	typedef struct packed {
		logic [2:0]         kind;
		logic [TSEL_W-1:0]  timer_select;
		logic [DELTA_W-1:0] delta_ms;
		logic [6:0]         load_minutes;
		logic [5:0]         load_seconds;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [8:0] gmt_day;
		logic [4:0] gmt_hour;
		logic [5:0] gmt_minute;
		logic [5:0] gmt_second;
		logic [9:0] gmt_milli;
		logic [8:0] met_day;
		logic [4:0] met_hour;
		logic [5:0] met_minute;
		logic [5:0] met_second;
		logic [9:0] met_milli;
		logic [6:0] event_minutes;
		logic [6:0] event_seconds;
	} result_t;

	// Display flags of the addressed event timer.
	typedef struct packed {
		logic test;
		logic none;
	} ev_flag_t;

	// State snapshot handed from the front to the back.
	typedef struct packed {
		logic [CLK_W-1:0] gmt_ms;
		logic [CLK_W-1:0] met_ms;
		logic [EV_W-1:0]  ev_ms;
		ev_flag_t         flags;
	} snap_t;

	// Broken-down clock, day counted from zero.
	typedef struct packed {
		logic [8:0] day0;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] milli;
	} clk_fields_t;

endpackage

// ----- rtl/mcet_front.sv -----
// Front part: accepts items and configuration writes and updates all timekeeping state.
module mcet_front import mcet_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MODE_W-1:0]    cfg_data,
	input  logic                 q_full,
	output logic                 push,
	output snap_t                push_data
);

	localparam int SUM_W = CLK_W + 1;

	logic [MODE_W-1:0] mode_q [NUM_MODE_REGS];
	logic [MODE_W-1:0] tmode  [NUM_EVENT_TIMERS];
	logic [CLK_W-1:0]  gmt_q, met_q, gmt_n, met_n;
	logic [EV_W-1:0]   cnt_q [NUM_EVENT_TIMERS];
	logic [EV_W-1:0]   cnt_n [NUM_EVENT_TIMERS];
	logic              run_q [NUM_EVENT_TIMERS];
	logic              run_n [NUM_EVENT_TIMERS];
	logic [12:0]       load_sec;
	logic [EV_W-1:0]   load_ms;
	logic              is_tick;
	logic              sel_ok;

	// Adds a tick to an accumulator and wraps past 400 days.
	function automatic logic [CLK_W-1:0] advance(input logic [CLK_W-1:0] acc,
			input logic [DELTA_W-1:0] delta);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(acc) + SUM_W'(delta);
		if (sum > SUM_W'(DAYS400_MS)) begin
			sum = sum - SUM_W'(DAYS400_MS);
		end
		return CLK_W'(sum);
	endfunction

	assign item_ready = !q_full;
	assign cfg_ready  = 1'b1;
	assign push       = item_valid && item_ready;
	assign is_tick    = (item.kind == KIND_TICK);
	assign sel_ok     = (int'(item.timer_select) < NUM_EVENT_TIMERS);

	// Per-timer mode; timers without a register count down.
	for (genvar t = 0; t < NUM_EVENT_TIMERS; t++) begin : g_mode
		if (t < NUM_MODE_REGS) begin : g_reg
			assign tmode[t] = mode_q[t];
		end else begin : g_fixed
			assign tmode[t] = MODE_DOWN;
		end
	end

	// Clock accumulators advance on ticks only.
	assign gmt_n = is_tick ? advance(gmt_q, item.delta_ms) : gmt_q;
	assign met_n = is_tick ? advance(met_q, item.delta_ms) : met_q;

	// Loaded value in milliseconds, saturated below.
	assign load_sec = 13'(item.load_minutes) * 13'd60 + 13'(item.load_seconds);
	assign load_ms  = 23'(load_sec) * 23'd1000;

	// Next state of every event timer.
	always_comb begin
		logic [EV_W:0] up_sum;
		for (int t = 0; t < NUM_EVENT_TIMERS; t++) begin
			cnt_n[t] = cnt_q[t];
			run_n[t] = run_q[t];
			up_sum   = (EV_W+1)'(cnt_q[t]) + (EV_W+1)'(item.delta_ms);
			if (is_tick) begin
				if (run_q[t]) begin
					case (tmode[t])
						MODE_UP: begin
							cnt_n[t] = (up_sum > (EV_W+1)'(EVENT_MAX_MS)) ?
								EVENT_MAX_MS : EV_W'(up_sum);
						end
						MODE_DOWN: begin
							if (cnt_q[t] > EV_W'(item.delta_ms)) begin
								cnt_n[t] = cnt_q[t] - EV_W'(item.delta_ms);
							end else begin
								cnt_n[t] = '0;
								run_n[t] = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end else if (sel_ok && item.timer_select == TSEL_W'(t)) begin
				case (item.kind)
					KIND_LOAD: begin
						cnt_n[t] = (load_ms > EVENT_MAX_MS) ? EVENT_MAX_MS : load_ms;
					end
					KIND_START: run_n[t] = 1'b1;
					KIND_STOP:  run_n[t] = 1'b0;
					KIND_CLEAR: cnt_n[t] = '0;
					default: begin
					end
				endcase
			end
		end
	end

	// Snapshot of the state after this item.
	always_comb begin
		push_data.gmt_ms     = gmt_n;
		push_data.met_ms     = met_n;
		push_data.ev_ms      = sel_ok ? cnt_n[item.timer_select] : '0;
		push_data.flags.none = !sel_ok;
		push_data.flags.test = sel_ok && (tmode[item.timer_select] == MODE_TEST);
	end

	// Timekeeping state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmt_q <= '0;
			met_q <= '0;
			for (int t = 0; t < NUM_EVENT_TIMERS; t++) begin
				cnt_q[t] <= '0;
				run_q[t] <= 1'b0;
			end
		end else if (push) begin
			gmt_q <= gmt_n;
			met_q <= met_n;
			for (int t = 0; t < NUM_EVENT_TIMERS; t++) begin
				cnt_q[t] <= cnt_n[t];
				run_q[t] <= run_n[t];
			end
		end
	end

	// Mode registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q[0] <= MODE_DOWN;
			mode_q[1] <= MODE_DOWN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIMER0_MODE: mode_q[0] <= cfg_data;
				REG_TIMER1_MODE: mode_q[1] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/mcet_fifo.sv -----
// Short snapshot queue between the front and the back.
module mcet_fifo import mcet_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  snap_t wdata,
	output logic  full,
	input  logic  pop,
	output snap_t rdata,
	output logic  empty
);

	snap_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + (FIFO_PTR_W+1)'(1))
		else $error("queue count did not follow a lone write");

endmodule

// ----- rtl/mcet_split.sv -----
// Seven-stage breakdown of a millisecond accumulator into day, hour, minute, second, millisecond.
module mcet_split import mcet_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [CLK_W-1:0] acc,
	output clk_fields_t      fields
);

	logic [36:0] p1;
	logic [56:0] p2;
	logic [52:0] p3;
	logic [40:0] p4;
	logic [28:0] p5;
	logic [17:0] r1;
	logic [25:0] secs;
	logic [27:0] ms_full;
	logic [25:0] sec_full;
	logic [19:0] min_full;
	logic [13:0] hour_full;

	// Stage registers.
	logic [17:0] h_s1;
	logic [17:0] lo_s1;
	logic [7:0]  q1_s1, q1_s2, q1_s3;
	logic [27:0] z_s2, z_s3;
	logic [17:0] q2_s3;
	logic [9:0]  ms_s4, ms_s5, ms_s6, ms_s7;
	logic [25:0] secs_s4;
	logic [19:0] q3_s4, q3_s5;
	logic [5:0]  sec_s5, sec_s6, sec_s7;
	logic [13:0] q4_s5, q4_s6;
	logic [5:0]  min_s6, min_s7;
	logic [8:0]  q5_s6;
	logic [4:0]  hour_s7;
	logic [8:0]  day_s7;

	// Reciprocal products and remainders, at most one reciprocal product per stage.
	always_comb begin
		p1        = 37'(acc[35:18]) * M_KILO_HI;
		r1        = h_s1 - 18'(q1_s1) * 18'd1000;
		p2        = 57'(z_s2) * M_KILO_LO;
		ms_full   = z_s3 - 28'(q2_s3) * 28'd1000;
		secs      = {q1_s3, q2_s3};
		p3        = 53'(secs) * M_SIXTY_S;
		sec_full  = secs_s4 - 26'(q3_s4) * 26'd60;
		p4        = 41'(q3_s4) * M_SIXTY_M;
		min_full  = q3_s5 - 20'(q4_s5) * 20'd60;
		p5        = 29'(q4_s5) * M_DAY_H;
		hour_full = q4_s6 - 14'(q5_s6) * 14'd24;
	end

	// Pipeline advance.
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1    <= acc[35:18];
			lo_s1   <= acc[17:0];
			q1_s1   <= p1[35:28];

			z_s2    <= {r1[9:0], lo_s1};
			q1_s2   <= q1_s1;

			z_s3    <= z_s2;
			q1_s3   <= q1_s2;
			q2_s3   <= p2[55:38];

			ms_s4   <= ms_full[9:0];
			secs_s4 <= secs;
			q3_s4   <= p3[51:32];

			ms_s5   <= ms_s4;
			sec_s5  <= sec_full[5:0];
			q3_s5   <= q3_s4;
			q4_s5   <= p4[39:26];

			ms_s6   <= ms_s5;
			sec_s6  <= sec_s5;
			min_s6  <= min_full[5:0];
			q4_s6   <= q4_s5;
			q5_s6   <= p5[27:19];

			ms_s7   <= ms_s6;
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hour_s7 <= hour_full[4:0];
			// Exactly 400 days shows as the first day.
			day_s7  <= (q5_s6 == DAYS_WRAP) ? '0 : q5_s6;
		end
	end

	assign fields.day0   = day_s7;
	assign fields.hour   = hour_s7;
	assign fields.minute = min_s7;
	assign fields.second = sec_s7;
	assign fields.milli  = ms_s7;

endmodule

// ----- rtl/mcet_back.sv -----
// Back part: breaks snapshots down into result fields and holds the result register.
module mcet_back import mcet_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  snap_t   q_data,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Event display carried through the later stages.
	typedef struct packed {
		logic [6:0] minutes;
		logic [5:0] seconds;
		ev_flag_t   flags;
	} ev_disp_t;

	logic                  adv;
	logic [NUM_STAGES-1:0] vld_q;
	logic                  result_valid_q;
	result_t               result_q;
	result_t               res_d;
	clk_fields_t           gmt_f, met_f;
	logic [46:0]           pe1;
	logic [26:0]           pe2;
	logic [12:0]           esec_full;
	logic [12:0]           evs_s1, evs_s2;
	ev_flag_t              flg_s1, flg_s2;
	logic [6:0]            evmin_s2;
	ev_disp_t              disp_s3;
	ev_disp_t              disp_dly_q [NUM_STAGES-3];
	ev_disp_t              disp_end;

	// Whole pipeline moves when the result register is free or being taken.
	assign adv          = !result_valid_q || result_ready;
	assign q_pop        = adv && !q_empty;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	mcet_split u_gmt (
		.clk    (clk),
		.en     (adv),
		.acc    (q_data.gmt_ms),
		.fields (gmt_f)
	);

	mcet_split u_met (
		.clk    (clk),
		.en     (adv),
		.acc    (q_data.met_ms),
		.fields (met_f)
	);

	// Event timer breakdown into whole minutes and seconds.
	always_comb begin
		pe1       = 47'(q_data.ev_ms) * M_EV_KILO;
		pe2       = 27'(evs_s1) * M_EV_SIXTY;
		esec_full = evs_s2 - 13'(evmin_s2) * 13'd60;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			evs_s1           <= pe1[45:33];
			flg_s1           <= q_data.flags;
			evs_s2           <= evs_s1;
			evmin_s2         <= pe2[25:19];
			flg_s2           <= flg_s1;
			disp_s3.minutes  <= evmin_s2;
			disp_s3.seconds  <= esec_full[5:0];
			disp_s3.flags    <= flg_s2;
			disp_dly_q[0]    <= disp_s3;
			for (int i = 1; i < NUM_STAGES - 3; i++) begin
				disp_dly_q[i] <= disp_dly_q[i-1];
			end
		end
	end

	assign disp_end = disp_dly_q[NUM_STAGES-4];

	// Result assembly.
	always_comb begin
		res_d.gmt_day    = gmt_f.day0 + 9'd1;
		res_d.gmt_hour   = gmt_f.hour;
		res_d.gmt_minute = gmt_f.minute;
		res_d.gmt_second = gmt_f.second;
		res_d.gmt_milli  = gmt_f.milli;
		res_d.met_day    = met_f.day0;
		res_d.met_hour   = met_f.hour;
		res_d.met_minute = met_f.minute;
		res_d.met_second = met_f.second;
		res_d.met_milli  = met_f.milli;
		if (disp_end.flags.none) begin
			res_d.event_minutes = '0;
			res_d.event_seconds = '0;
		end else if (disp_end.flags.test) begin
			res_d.event_minutes = TEST_SHOW;
			res_d.event_seconds = TEST_SHOW;
		end else begin
			res_d.event_minutes = disp_end.minutes;
			res_d.event_seconds = 7'(disp_end.seconds);
		end
	end

	// Stage valid bits and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q          <= {vld_q[NUM_STAGES-2:0], q_pop};
			result_valid_q <= vld_q[NUM_STAGES-1];
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_d;
		end
	end

endmodule

// ----- rtl/mission_clock_event_timers.sv -----
// Top level of the mission clock with two event timers.
//
//  Channel   Signals                                     Direction
//  item      item_valid, item_ready, item (item_t)       in
//  result    result_valid, result_ready, result          out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// One item is accepted per cycle while item_ready is high; all state is updated in the accepting cycle.
// An item's snapshot passes through the queue, a seven-stage constant-divisor
// breakdown and the result register before its result appears.
// Reset clears both clocks, both event timers and their running flags; modes count down.
// A stalled result holds the breakdown pipeline; the four-entry snapshot queue
// then fills and item_ready falls. Configuration writes are always taken.
module mission_clock_event_timers import mcet_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MODE_W-1:0]    cfg_data
);

	logic  q_full, q_empty, push, pop;
	snap_t push_data, pop_data;

	mcet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	mcet_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (q_full),
		.pop    (pop),
		.rdata  (pop_data),
		.empty  (q_empty)
	);

	mcet_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
